### hw/rtl/assert_macros.svh
// Assertion macros shared by the motion profiler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check, switched off while reset is high
`define TMPROF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also runs during reset
`define TMPROF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TMPROF_ASSERT(lbl, clk, rst, prop, msg)
`define TMPROF_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

### hw/rtl/tmprof_pkg.sv
// Types and constants shared by the trapezoidal motion profiler modules.
package tmprof_pkg;

   // Fixed point format
   localparam int FRAC_BITS = 16;

   // Field widths
   localparam int ACT_W   = 2;
   localparam int POS_W   = 32;
   localparam int SPD_W   = 21;
   localparam int ACC_W   = 16;
   localparam int LIM_W   = 20;
   localparam int MAXS_W  = 20;

   // Arrival and stopping tolerances, rounded to the nearest fixed point step
   localparam longint ARRIVE_TOL = ((longint'(1) << FRAC_BITS) + 50) / 100;
   localparam longint STOP_TOL   = ((longint'(1) << FRAC_BITS) + 5) / 10;
   localparam int     TOL_W      = $clog2(STOP_TOL + 1);

   // Internal arithmetic widths
   localparam int SQ_W   = 2 * SPD_W - 1;        // speed squared, unsigned
   localparam int DIV_W  = ACC_W + 1;            // twice the acceleration
   localparam int TOGO_W = POS_W + 1;            // distance to go, unsigned
   localparam int PGO_W  = TOGO_W + DIV_W;       // distance to go times divisor
   localparam int PST_W  = TOL_W + DIV_W;        // stopping tolerance times divisor

   localparam logic [TOL_W-1:0]  STOP_TOL_Q   = TOL_W'(STOP_TOL);
   localparam logic [TOGO_W-1:0] ARRIVE_TOL_Q = TOGO_W'(ARRIVE_TOL);

   // Saturation limits
   localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
   localparam logic signed [SPD_W-1:0] SPD_MAX = {1'b0, {(SPD_W-1){1'b1}}};
   localparam logic signed [SPD_W-1:0] SPD_MIN = {1'b1, {(SPD_W-1){1'b0}}};

   // Request actions
   typedef enum logic [ACT_W-1:0] {
      ACT_MOVE  = 2'd0,
      ACT_DECEL = 2'd1,
      ACT_STOP  = 2'd2,
      ACT_LOAD  = 2'd3
   } action_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_MUL,
      ST_EXEC
   } ctrl_state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;   // latch the request fields
      logic prep;      // square the speed, form distance to go and divisor
      logic mul;       // form the comparison products
      logic commit;    // update carriage state and load the response
   } dp_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic move_cmd;  // latched request is a move and needs the products
   } dp_sts_type;

   // Register map
   localparam logic REG_ACCEL    = 1'b0;
   localparam logic REG_MAXSPEED = 1'b1;

endpackage

### hw/rtl/tmprof_csr.sv
// Configuration registers of the motion profiler behind an APB-style port.
module tmprof_csr import tmprof_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready,
   output logic [ACC_W-1:0]  acceleration,
   output logic [MAXS_W-1:0] max_speed
);

   logic [ACC_W-1:0]  accel_ff;
   logic [ACC_W-1:0]  accel_in;
   logic [MAXS_W-1:0] maxspd_ff;
   logic [MAXS_W-1:0] maxspd_in;
   logic              wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   // Register write decode on the word address bit
   always_comb begin
      accel_in  = accel_ff;
      maxspd_in = maxspd_ff;
      if (wr_en) begin
         case (paddr[2])
            REG_ACCEL:    accel_in  = pwdata[ACC_W-1:0];
            REG_MAXSPEED: maxspd_in = pwdata[MAXS_W-1:0];
            default:      accel_in  = accel_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_ff  <= ACC_W'(66);
         maxspd_ff <= MAXS_W'(65536);
      end else begin
         accel_ff  <= accel_in;
         maxspd_ff <= maxspd_in;
      end
   end

   // Read back
   always_comb begin
      case (paddr[2])
         REG_ACCEL:    prdata = {{(32-ACC_W){1'b0}}, accel_ff};
         REG_MAXSPEED: prdata = {{(32-MAXS_W){1'b0}}, maxspd_ff};
         default:      prdata = '0;
      endcase
   end

   assign acceleration = accel_ff;
   assign max_speed    = maxspd_ff;

endmodule

### hw/rtl/tmprof_ctrl.sv
// Sequencing state machine of the motion profiler and the response valid flag.
`include "assert_macros.svh"

module tmprof_ctrl import tmprof_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   logic           slot_free;

   // Response register can take a new result
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_PREP;
         end
         ST_PREP: begin
            state_in = sts.move_cmd ? ST_MUL : ST_EXEC;
         end
         ST_MUL: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_stall   = 1'b1;
      cmd         = '0;
      case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_PREP: cmd.prep   = 1'b1;
         ST_MUL:  cmd.mul    = 1'b1;
         ST_EXEC: cmd.commit = slot_free;
         default: req_stall  = 1'b1;
      endcase
   end

   // Response valid: set on commit, held while the receiver stalls
   assign rsp_valid_in = cmd.commit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `TMPROF_ASSERT(a_accept_starts, clock, reset, (req_valid && !req_stall) |=> (state_ff == ST_PREP), "accepted request did not start the sequence")
   `TMPROF_ASSERT(a_no_overwrite, clock, reset, (rsp_valid_ff && rsp_stall) |-> !cmd.commit, "commit over a pending response")
   `TMPROF_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (state_ff == ST_IDLE && !rsp_valid_ff), "reset did not clear the controller")

endmodule

### hw/rtl/tmprof_datapath.sv
// Datapath of the motion profiler: carriage state, stopping tests and integration.
`include "assert_macros.svh"

module tmprof_datapath import tmprof_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  dp_cmd_type               cmd,
   output dp_sts_type               sts,
   input  logic [ACT_W-1:0]         req_action,
   input  logic signed [POS_W-1:0]  req_target,
   input  logic [LIM_W-1:0]         req_speed_limit,
   input  logic [ACC_W-1:0]         acceleration,
   input  logic [MAXS_W-1:0]        max_speed,
   output logic                     rsp_done_res,
   output logic signed [POS_W-1:0]  rsp_position_out,
   output logic signed [SPD_W-1:0]  rsp_speed_out
);

   // Latched request
   action_type               act_ff;
   logic signed [POS_W-1:0]  tgt_ff;
   logic [LIM_W-1:0]         lim_ff;

   // Carriage state and response flag
   logic signed [POS_W-1:0]  pos_ff;
   logic signed [POS_W-1:0]  pos_in;
   logic signed [SPD_W-1:0]  spd_ff;
   logic signed [SPD_W-1:0]  spd_in;
   logic                     done_ff;
   logic                     done_in;

   // First stage: square, distance to go, divisor
   logic signed [2*SPD_W-1:0] sq_full;
   logic [SQ_W-1:0]           sq_ff;
   logic [SQ_W-1:0]           sq_in;
   logic signed [POS_W:0]     diff;
   logic [TOGO_W-1:0]         togo_ff;
   logic [TOGO_W-1:0]         togo_in;
   logic                      dir_pos_ff;
   logic                      dir_pos_in;
   logic [DIV_W-1:0]          div_ff;
   logic [DIV_W-1:0]          div_in;

   // Second stage: comparison products
   logic [PGO_W-1:0]          pgo_ff;
   logic [PGO_W-1:0]          pgo_in;
   logic [PST_W-1:0]          pst_ff;
   logic [PST_W-1:0]          pst_in;

   // Step evaluation
   logic [SPD_W-1:0]          spd_mag;
   logic                      arrive;
   logic                      brake;
   logic                      accel_ok;
   logic                      decel_stop;
   logic                      a_zero;
   logic                      a_neg;
   logic signed [ACC_W+1:0]   acc_s;
   logic signed [ACC_W+1:0]   a_val;
   logic signed [ACC_W+1:0]   half;
   logic signed [POS_W+1:0]   pos_sum;
   logic signed [SPD_W+1:0]   spd_sum;
   logic signed [POS_W-1:0]   pos_sat;
   logic signed [SPD_W-1:0]   spd_sat;
   logic signed [SPD_W:0]     spd_ext;
   logic signed [SPD_W:0]     lim_s;
   logic signed [SPD_W-1:0]   spd_clamp;
   logic                      spd_in_lim;

   assign sts.move_cmd = (act_ff == ACT_MOVE);

   // Stage one arithmetic
   assign sq_full    = (2*SPD_W)'(spd_ff) * (2*SPD_W)'(spd_ff);
   assign sq_in      = sq_full[SQ_W-1:0];
   assign diff       = $signed({tgt_ff[POS_W-1], tgt_ff}) - $signed({pos_ff[POS_W-1], pos_ff});
   assign togo_in    = diff[POS_W] ? TOGO_W'(-diff) : TOGO_W'(diff);
   assign dir_pos_in = !diff[POS_W] && (diff != '0);
   // zero acceleration divides as if it were one
   assign div_in     = (acceleration == '0) ? DIV_W'(2) : {acceleration, 1'b0};

   // Stage two products
   assign pgo_in = PGO_W'(togo_ff) * PGO_W'(div_ff);
   assign pst_in = PST_W'(STOP_TOL_Q) * PST_W'(div_ff);

   // Magnitude of the speed, the most negative value maps to its unsigned magnitude
   assign spd_mag = spd_ff[SPD_W-1] ? SPD_W'(-spd_ff) : SPD_W'(spd_ff);

   // floor(sq/div) < tol  <=>  sq < tol*div ; floor(sq/div) >= togo  <=>  sq >= togo*div
   assign arrive     = (togo_ff <= ARRIVE_TOL_Q) && (PGO_W'(sq_ff) < PGO_W'(pst_ff));
   assign brake      = (PGO_W'(sq_ff) >= pgo_ff);
   assign accel_ok   = (spd_mag < SPD_W'(max_speed));
   assign decel_stop = (spd_mag < SPD_W'(acceleration));

   // Signed acceleration for this step
   always_comb begin
      a_zero = 1'b1;
      a_neg  = 1'b0;
      case (act_ff)
         ACT_MOVE: begin
            if (brake) begin
               a_zero = 1'b0;
               a_neg  = dir_pos_ff;
            end else if (accel_ok) begin
               a_zero = 1'b0;
               a_neg  = !dir_pos_ff;
            end
         end
         ACT_DECEL: begin
            a_zero = 1'b0;
            a_neg  = (spd_ff > 0);
         end
         default: a_zero = 1'b1;
      endcase
   end

   assign acc_s = $signed({2'b00, acceleration});
   assign a_val = a_zero ? '0 : (a_neg ? -acc_s : acc_s);
   assign half  = a_zero ? '0 : (a_neg ? -(acc_s >>> 1) : (acc_s >>> 1));

   // Integration with saturation
   assign pos_sum = $signed({{2{pos_ff[POS_W-1]}}, pos_ff})
                  + $signed({{(POS_W+2-SPD_W){spd_ff[SPD_W-1]}}, spd_ff})
                  + (POS_W+2)'(half);
   assign spd_sum = $signed({{2{spd_ff[SPD_W-1]}}, spd_ff}) + (SPD_W+2)'(a_val);

   always_comb begin
      if ((pos_sum[POS_W+1:POS_W-1] == 3'b000) || (pos_sum[POS_W+1:POS_W-1] == 3'b111)) begin
         pos_sat = pos_sum[POS_W-1:0];
      end else begin
         pos_sat = pos_sum[POS_W+1] ? POS_MIN : POS_MAX;
      end
      if ((spd_sum[SPD_W+1:SPD_W-1] == 3'b000) || (spd_sum[SPD_W+1:SPD_W-1] == 3'b111)) begin
         spd_sat = spd_sum[SPD_W-1:0];
      end else begin
         spd_sat = spd_sum[SPD_W+1] ? SPD_MIN : SPD_MAX;
      end
   end

   // Clamp to the request's speed limit
   assign spd_ext = $signed({spd_sat[SPD_W-1], spd_sat});
   assign lim_s   = $signed({2'b00, lim_ff});
   always_comb begin
      if (spd_ext > lim_s) begin
         spd_clamp = SPD_W'(lim_s);
      end else if (spd_ext < -lim_s) begin
         spd_clamp = SPD_W'(-lim_s);
      end else begin
         spd_clamp = spd_sat;
      end
   end

   // New carriage state per action
   always_comb begin
      pos_in  = pos_ff;
      spd_in  = spd_ff;
      done_in = 1'b0;
      case (act_ff)
         ACT_MOVE: begin
            if (arrive) begin
               spd_in  = '0;
               done_in = 1'b1;
            end else begin
               pos_in = pos_sat;
               spd_in = spd_clamp;
            end
         end
         ACT_DECEL: begin
            if (decel_stop) begin
               spd_in  = '0;
               done_in = 1'b1;
            end else begin
               pos_in = pos_sat;
               spd_in = spd_sat;
            end
         end
         ACT_STOP: spd_in = '0;
         ACT_LOAD: pos_in = tgt_ff;
         default:  done_in = 1'b0;
      endcase
   end

   // Carriage state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         spd_ff <= '0;
      end else if (cmd.commit) begin
         pos_ff <= pos_in;
         spd_ff <= spd_in;
      end
   end

   // Request latch, intermediate results and response flag
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff <= action_type'(req_action);
         tgt_ff <= req_target;
         lim_ff <= req_speed_limit;
      end
      if (cmd.prep) begin
         sq_ff      <= sq_in;
         togo_ff    <= togo_in;
         dir_pos_ff <= dir_pos_in;
         div_ff     <= div_in;
      end
      if (cmd.mul) begin
         pgo_ff <= pgo_in;
         pst_ff <= pst_in;
      end
      if (cmd.commit) begin
         done_ff <= done_in;
      end
   end

   assign rsp_done_res     = done_ff;
   assign rsp_position_out = pos_ff;
   assign rsp_speed_out    = spd_ff;

   assign spd_in_lim = (spd_mag <= {1'b0, lim_ff});

   `TMPROF_ASSERT(a_done_zero_speed, clock, reset, (cmd.commit && done_in) |=> (spd_ff == '0), "speed not zero after arrival")
   `TMPROF_ASSERT(a_move_within_limit, clock, reset, (cmd.commit && act_ff == ACT_MOVE) |=> spd_in_lim, "move left speed above its limit")

endmodule

### hw/rtl/trapezoidal_motion_profiler.sv
// Top level of the trapezoidal motion profiler.
//
// One request per control tick on the req_ channel (action, target, speed limit);
// each request gives exactly one response on the rsp_ channel carrying the done
// flag and the carriage position and speed after the step.
// A request is taken when req_valid is high and req_stall low; a response is
// taken when rsp_valid is high and rsp_stall low.
// An accepted request is captured; the sequencer then forms speed squared,
// distance to go and divisor, for a move then the two comparison products,
// and last integrates and commits. The block then returns to idle; a new
// request is taken only once the previous one has committed.
// A response waiting in the output register does not block the next request;
// the block only holds its final step while the receiver stalls a pending one.
// Acceleration and maximum speed are written over the APB-style port; the
// user must write them only while idle, the block itself does not enforce it.
// Reset clears position and speed to zero, empties the response register and
// loads acceleration 66 and maximum speed 65536.
module trapezoidal_motion_profiler import tmprof_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [ACT_W-1:0]        req_action,
   input  logic signed [POS_W-1:0] req_target,
   input  logic [LIM_W-1:0]        req_speed_limit,
   // response channel
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_done_res,
   output logic signed [POS_W-1:0] rsp_position_out,
   output logic signed [SPD_W-1:0] rsp_speed_out,
   // configuration port
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [2:0]              paddr,
   input  logic [31:0]             pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   dp_cmd_type        cmd;
   dp_sts_type        sts;
   logic [ACC_W-1:0]  acceleration;
   logic [MAXS_W-1:0] max_speed;

   tmprof_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .acceleration (acceleration),
      .max_speed    (max_speed)
   );

   tmprof_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   tmprof_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_action       (req_action),
      .req_target       (req_target),
      .req_speed_limit  (req_speed_limit),
      .acceleration     (acceleration),
      .max_speed        (max_speed),
      .rsp_done_res     (rsp_done_res),
      .rsp_position_out (rsp_position_out),
      .rsp_speed_out    (rsp_speed_out)
   );

endmodule

### test/tb_trapezoidal_motion_profiler.sv
`timescale 1ns / 1ps
// Self-checking testbench for the trapezoidal motion profiler: directed and random requests.
module tb_trapezoidal_motion_profiler;
   import tmprof_pkg::*;

   localparam int HALF_PERIOD  = 10;
   localparam int RESET_CYCLES = 10;
   localparam int DRAIN_CYCLES = 8;
   localparam int IDLE_LIMIT   = 5000;
   localparam int REPORT_LINES = 40;

   localparam longint POS_HI  = (longint'(1) << (POS_W - 1)) - 1;
   localparam longint POS_LO  = -(longint'(1) << (POS_W - 1));
   localparam longint SPD_HI  = (longint'(1) << (SPD_W - 1)) - 1;
   localparam longint SPD_LO  = -(longint'(1) << (SPD_W - 1));
   localparam int     LIM_TOP = (1 << LIM_W) - 1;
   localparam int     ACC_TOP = (1 << ACC_W) - 1;
   localparam int     MAXS_TOP = (1 << MAXS_W) - 1;

   localparam longint ACCEL_AT_RESET     = 66;
   localparam longint MAX_SPEED_AT_RESET = 65536;

   // Byte addresses of the two registers
   localparam logic [2:0] ADDR_ACCEL     = {REG_ACCEL, 2'b00};
   localparam logic [2:0] ADDR_MAX_SPEED = {REG_MAXSPEED, 2'b00};

   typedef struct {
      logic                    done;
      logic signed [POS_W-1:0] pos;
      logic signed [SPD_W-1:0] spd;
   } carriage_result_type;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic [ACT_W-1:0]        req_action;
   logic signed [POS_W-1:0] req_target;
   logic [LIM_W-1:0]        req_speed_limit;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic                    rsp_done_res;
   logic signed [POS_W-1:0] rsp_position_out;
   logic signed [SPD_W-1:0] rsp_speed_out;
   logic                    psel;
   logic                    penable;
   logic                    pwrite;
   logic [2:0]              paddr;
   logic [31:0]             pwdata;
   logic [31:0]             prdata;
   logic                    pready;

   // Predicted carriage state and register copies
   longint car_pos;
   longint car_spd;
   longint cfg_accel;
   longint cfg_max_speed;

   carriage_result_type predicted_steps[$];

   int n_requests;
   int n_responses = 0;
   int n_settings;
   int n_errors = 0;
   int send_idle_pct;
   int rsp_stall_pct;
   int idle_cycles;

   trapezoidal_motion_profiler u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_target       (req_target),
      .req_speed_limit  (req_speed_limit),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_done_res     (rsp_done_res),
      .rsp_position_out (rsp_position_out),
      .rsp_speed_out    (rsp_speed_out),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always #HALF_PERIOD clock = ~clock;

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint magnitude(longint v);
      return v < 0 ? -v : v;
   endfunction

   // One tick of integration; half of the acceleration truncated toward zero
   function automatic void apply_accel(longint a);
      longint half;
      half = magnitude(a) / 2;
      if (a < 0) half = -half;
      car_pos = clamp(car_pos + car_spd + half, POS_LO, POS_HI);
      car_spd = clamp(car_spd + a, SPD_LO, SPD_HI);
   endfunction

   // Predicted response of one request; updates the carriage copy
   function automatic carriage_result_type advance_carriage(action_type act,
                                                        logic signed [POS_W-1:0] tgt,
                                                        logic [LIM_W-1:0] lim);
      carriage_result_type res;
      longint goal, togo, dir, dstop, divisor, a, lim_v;
      goal  = longint'(tgt);
      lim_v = longint'(lim);
      res.done = 1'b0;
      case (act)
         ACT_MOVE: begin
            togo    = magnitude(goal - car_pos);
            dir     = (goal > car_pos) ? 1 : -1;
            divisor = (cfg_accel == 0) ? 2 : 2 * cfg_accel;
            dstop   = (car_spd * car_spd) / divisor;
            if (togo <= ARRIVE_TOL && dstop < STOP_TOL) begin
               car_spd  = 0;
               res.done = 1'b1;
            end else begin
               a = 0;
               if (dstop >= togo) a = -cfg_accel * dir;
               else if (magnitude(car_spd) < cfg_max_speed) a = cfg_accel * dir;
               apply_accel(a);
               car_spd = clamp(car_spd, -lim_v, lim_v);
            end
         end
         ACT_DECEL: begin
            dir = (car_spd > 0) ? 1 : -1;
            if (magnitude(car_spd) < cfg_accel) begin
               car_spd  = 0;
               res.done = 1'b1;
            end else begin
               apply_accel(-cfg_accel * dir);
            end
         end
         ACT_STOP: car_spd = 0;
         default:  car_pos = goal;
      endcase
      res.pos = car_pos[POS_W-1:0];
      res.spd = car_spd[SPD_W-1:0];
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      n_errors++;
      // keep the log short when the design is badly broken
      if (n_errors <= REPORT_LINES) $display("%0t ns: mismatch, %s", $time, what);
   endtask

   // Drive one request and record its predicted response once taken
   task automatic send_request(input action_type act, input logic signed [POS_W-1:0] tgt,
                               input logic [LIM_W-1:0] lim, output logic done);
      carriage_result_type step;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= act;
      req_target      <= tgt;
      req_speed_limit <= lim;
      do @(posedge clock); while (req_stall);
      step = advance_carriage(act, tgt, lim);
      predicted_steps.push_back(step);
      n_requests++;
      done = step.done;
   endtask

   task automatic send_noise();
      logic done;
      send_request(action_type'($urandom_range(3)), $urandom, LIM_W'($urandom), done);
   endtask

   task automatic wait_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (predicted_steps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One register access: setup cycle then access cycle
   task automatic csr_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= addr;
      pwdata  <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic check_registers();
      logic [31:0] rd;
      csr_access(1'b0, ADDR_ACCEL, '0, rd);
      if (rd !== 32'(cfg_accel))
         report_mismatch($sformatf("acceleration reads %0d, expected %0d", rd, cfg_accel));
      csr_access(1'b0, ADDR_MAX_SPEED, '0, rd);
      if (rd !== 32'(cfg_max_speed))
         report_mismatch($sformatf("max speed reads %0d, expected %0d", rd, cfg_max_speed));
   endtask

   // Register writes only once the block has gone quiet
   task automatic configure(input longint accel, input longint max_spd);
      logic [31:0] rd;
      wait_until_drained();
      csr_access(1'b1, ADDR_ACCEL, 32'(accel), rd);
      cfg_accel = accel;
      csr_access(1'b1, ADDR_MAX_SPEED, 32'(max_spd), rd);
      cfg_max_speed = max_spd;
      check_registers();
      n_settings++;
   endtask

   function automatic longint pick_accel();
      int r;
      r = $urandom_range(99);
      if (r < 8) return 1;
      if (r < 16) return longint'(ACC_TOP);
      return longint'($urandom_range(200, ACC_TOP));
   endfunction

   function automatic longint pick_max_speed();
      int r;
      r = $urandom_range(99);
      if (r < 8) return 1;
      if (r < 16) return longint'(MAXS_TOP);
      return longint'($urandom_range(1, MAXS_TOP));
   endfunction

   // Mostly complete moves towards a nearby goal, with some braking, stops, loads and noise
   task automatic run_episode();
      int r, steps;
      longint offset, goal;
      logic [LIM_W-1:0] lim;
      logic done;
      r    = $urandom_range(99);
      done = 1'b0;
      steps = 0;
      if (r < 70) begin
         offset = longint'($urandom_range(0, int'(cfg_accel * 400 + 2000)));
         if ($urandom_range(1)) offset = -offset;
         goal = clamp(car_pos + offset, POS_LO, POS_HI);
         if ($urandom_range(99) < 75) lim = LIM_W'($urandom_range(int'(cfg_accel) * 8, LIM_TOP));
         else lim = LIM_W'($urandom);
         while (!done && steps < 60) begin
            if ($urandom_range(99) < 4) send_noise();
            else send_request(ACT_MOVE, POS_W'(goal), lim, done);
            steps++;
         end
      end else if (r < 82) begin
         while (!done && steps < 40) begin
            send_request(ACT_DECEL, $urandom, LIM_W'($urandom), done);
            steps++;
         end
      end else if (r < 88) begin
         send_request(ACT_STOP, $urandom, LIM_W'($urandom), done);
      end else if (r < 94) begin
         case ($urandom_range(2))
            0:       goal = longint'($urandom) + POS_LO;
            1:       goal = POS_HI - $urandom_range(0, 1 << 20);
            default: goal = POS_LO + $urandom_range(0, 1 << 20);
         endcase
         send_request(ACT_LOAD, POS_W'(goal), LIM_W'($urandom), done);
      end else begin
         send_noise();
      end
   endtask

   task automatic test_reset_values();
      check_registers();
   endtask

   // Tolerance edges, every action, position saturation both ways
   task automatic test_directed();
      logic done;
      send_request(ACT_LOAD, 0, 0, done);
      send_request(ACT_MOVE, 0, LIM_W'(LIM_TOP), done);
      send_request(ACT_MOVE, POS_W'(ARRIVE_TOL), LIM_W'(LIM_TOP), done);
      send_request(ACT_MOVE, POS_W'(-ARRIVE_TOL), LIM_W'(LIM_TOP), done);
      send_request(ACT_MOVE, POS_W'(ARRIVE_TOL + 1), LIM_W'(LIM_TOP), done);
      // zero limit clamps the speed
      send_request(ACT_MOVE, 1000000, 0, done);
      repeat (3) send_request(ACT_MOVE, 1000000, LIM_W'(LIM_TOP), done);
      send_request(ACT_LOAD, POS_W'(POS_HI - 50), 0, done);
      repeat (4) send_request(ACT_DECEL, $urandom, LIM_W'($urandom), done);
      send_request(ACT_LOAD, 0, 0, done);
      repeat (2) send_request(ACT_MOVE, -1000000, LIM_W'(LIM_TOP), done);
      send_request(ACT_LOAD, POS_W'(POS_LO + 20), 0, done);
      repeat (2) send_request(ACT_DECEL, 0, 0, done);
      send_request(ACT_MOVE, POS_W'(POS_HI), LIM_W'(LIM_TOP), done);
      send_request(ACT_STOP, $urandom, LIM_W'($urandom), done);
   endtask

   // Largest register values and the value one for both; speed saturation
   task automatic test_config_extremes();
      logic done;
      int steps;
      configure(longint'(ACC_TOP), longint'(MAXS_TOP));
      send_request(ACT_STOP, 0, 0, done);
      send_request(ACT_LOAD, 0, 0, done);
      repeat (17) send_request(ACT_MOVE, POS_W'(POS_HI), LIM_W'(LIM_TOP), done);
      send_request(ACT_LOAD, POS_W'(POS_HI - 100), 0, done);
      send_request(ACT_MOVE, POS_W'(POS_HI), LIM_W'(LIM_TOP), done);
      steps = 0;
      done  = 1'b0;
      while (!done && steps < 40) begin
         send_request(ACT_DECEL, 0, 0, done);
         steps++;
      end
      configure(1, 1);
      send_request(ACT_LOAD, 0, 0, done);
      repeat (3) send_request(ACT_MOVE, 1000000, LIM_W'(LIM_TOP), done);
      repeat (2) send_request(ACT_DECEL, 0, 0, done);
   endtask

   // Zero acceleration: stopping distance uses a divisor of two, decelerate never finishes
   task automatic test_zero_acceleration();
      logic done;
      configure(300, MAX_SPEED_AT_RESET);
      send_request(ACT_LOAD, 0, 0, done);
      repeat (3) send_request(ACT_MOVE, 1000000, LIM_W'(LIM_TOP), done);
      configure(0, 0);
      send_request(ACT_MOVE, 1000000, LIM_W'(LIM_TOP), done);
      send_request(ACT_MOVE, POS_W'(car_pos + 1000), LIM_W'(LIM_TOP), done);
      send_request(ACT_DECEL, 0, 0, done);
      send_request(ACT_STOP, 0, 0, done);
      send_request(ACT_MOVE, POS_W'(car_pos), 0, done);
   endtask

   task automatic test_random_traffic(input int sender_idle, input int receiver_stall,
                                      input int quota);
      int stop_at, next_setting;
      send_idle_pct = sender_idle;
      rsp_stall_pct = receiver_stall;
      stop_at = n_requests + quota;
      while (n_requests < stop_at) begin
         configure(pick_accel(), pick_max_speed());
         next_setting = n_requests + 160;
         while (n_requests < next_setting && n_requests < stop_at) run_episode();
      end
   endtask

   // Receiver back-pressure
   always @(negedge clock) rsp_stall <= ($urandom_range(99) < rsp_stall_pct);

   // Response checker
   always @(posedge clock) begin : check_responses
      carriage_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         n_responses++;
         if (predicted_steps.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            want = predicted_steps.pop_front();
            if (rsp_done_res !== want.done)
               report_mismatch($sformatf("done %0b, expected %0b", rsp_done_res, want.done));
            if (rsp_position_out !== want.pos)
               report_mismatch($sformatf("position %0d, expected %0d",
                                         rsp_position_out, want.pos));
            if (rsp_speed_out !== want.spd)
               report_mismatch($sformatf("speed %0d, expected %0d", rsp_speed_out, want.spd));
         end
      end
   end

   // Watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t ns: no progress for %0d cycles", $time, IDLE_LIMIT);
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_action      = ACT_MOVE;
      req_target      = '0;
      req_speed_limit = '0;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = '0;
      n_requests      = 0;
      n_settings      = 0;
      send_idle_pct   = 21;
      rsp_stall_pct   = 87;
      car_pos         = 0;
      car_spd         = 0;
      cfg_accel       = ACCEL_AT_RESET;
      cfg_max_speed   = MAX_SPEED_AT_RESET;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_directed();
      test_config_extremes();
      test_zero_acceleration();
      test_random_traffic(21, 87, 630);
      test_random_traffic(87, 21, 630);
      test_random_traffic(0, 0, 630);
      wait_until_drained();

      $display("%0d requests and %0d responses over %0d register settings,", n_requests,
               n_responses, n_settings);
      $display("all four actions under three idle and stall patterns; %0d mismatches",
               n_errors);
      if (n_errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
